// File: sv/lru_k_cache_policy_core_defines.svh
// ----------------------------------------------------------------------------
// lru_k_cache_policy_core_defines
// assertion macros used by the checker file of the lru-k policy core
// ----------------------------------------------------------------------------
`ifndef LRU_K_CACHE_POLICY_CORE_DEFINES_SVH
`define LRU_K_CACHE_POLICY_CORE_DEFINES_SVH

// checked on every rising clock edge, reset included
`define LKC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// checked only outside reset
`define LKC_ASSERT(lbl, prop, msg) \
  `LKC_ASSERT_CLK(lbl, disable iff (!rst_ni) prop, msg)

`endif

// File: sv/lkc_pkg.sv
// ----------------------------------------------------------------------------
// lkc_pkg
// types and constants of the lru-k cache policy core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lkc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned KEY_BITS_DEF    = 10;

  // access counter
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  // configuration registers
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned THR_W   = 4;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned REG_SEL_BIT = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [THR_W-1:0] THR_RESET = 4'd2;
  localparam logic [THR_W-1:0] THR_MIN   = 4'd2;
  localparam logic [THR_W-1:0] THR_MAX   = 4'd14;

  typedef enum logic [0:0] {
    REG_CAPACITY  = 1'b0,
    REG_THRESHOLD = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    OUT_NEW           = 3'd0,
    OUT_HIST_REFRESH  = 3'd1,
    OUT_PROMOTED      = 3'd2,
    OUT_CACHE_REFRESH = 3'd3,
    OUT_DUMP          = 3'd4
  } outcome_e;

  typedef enum logic [0:0] {
    Q_HIST  = 1'b0,
    Q_CACHE = 1'b1
  } queue_e;

endpackage

`default_nettype wire

// File: sv/lkc_if.sv
// ----------------------------------------------------------------------------
// lkc_if
// valid/ready channels of the lru-k cache policy core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lkc_in_if import lkc_pkg::*; #(
  parameter int unsigned KeyBits = KEY_BITS_DEF
) ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [KeyBits-1:0] access_key;

  modport source (output valid, output action, output access_key, input ready);
  modport sink   (input valid, input action, input access_key, output ready);
endinterface

interface lkc_out_if import lkc_pkg::*; #(
  parameter int unsigned KeyBits = KEY_BITS_DEF
) ();
  logic               valid;
  logic               ready;
  logic [2:0]         outcome;
  logic               evicted_valid;
  logic [KeyBits-1:0] evicted_key;
  logic               evicted_from;
  logic               dump_valid;
  logic [KeyBits-1:0] dump_key;
  logic               dump_queue;
  logic               last;

  modport source (
    output valid, output outcome, output evicted_valid, output evicted_key,
    output evicted_from, output dump_valid, output dump_key, output dump_queue,
    output last, input ready
  );
  modport sink (
    input valid, input outcome, input evicted_valid, input evicted_key,
    input evicted_from, input dump_valid, input dump_key, input dump_queue,
    input last, output ready
  );
endinterface

`default_nettype wire

// File: sv/lru_k_cache_policy_core.sv
// ----------------------------------------------------------------------------
// lru_k_cache_policy_core
// lru-k replacement: history and cache queues with a per-key access count
// access: the shared key comparator steps through one queue slot per cycle
// dump: one result per cycle while the output is taken
// after reset the count ram is swept to zero, input not ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_k_cache_policy_core import lkc_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF,
  parameter int unsigned KeyBits    = KEY_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lkc_in_if.sink             in_i,
  lkc_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned FillW   = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CmpW    = (FillW > CAP_W) ? FillW : CAP_W;
  localparam int unsigned KeySpan = 2 ** KeyBits;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CLEAR  = 10'b00_0000_0010,
    S_READ   = 10'b00_0000_0100,
    S_COUNT  = 10'b00_0000_1000,
    S_SCAN   = 10'b00_0001_0000,
    S_REMOVE = 10'b00_0010_0000,
    S_EVICT  = 10'b00_0100_0000,
    S_APPEND = 10'b00_1000_0000,
    S_RESULT = 10'b01_0000_0000,
    S_DUMP   = 10'b10_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REFRESH,
    OP_PROMO_HIST,
    OP_PROMO_CACHE
  } op_e;

  typedef struct packed {
    outcome_e           outcome;
    logic               evicted_valid;
    logic [KeyBits-1:0] evicted_key;
    queue_e             evicted_from;
    logic               dump_valid;
    logic [KeyBits-1:0] dump_key;
    queue_e             dump_queue;
    logic               last;
  } res_t;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  queue_e             qsel_q, qsel_d;
  outcome_e           outcome_q, outcome_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [FillW-1:0]   scan_q, scan_d;
  logic [FillW-1:0]   pos_q, pos_d;
  logic               ev_q, ev_d;
  queue_e             ev_from_q, ev_from_d;
  logic [KeyBits-1:0] victim_q, victim_d;
  logic [KeyBits-1:0] clr_q, clr_d;
  logic [CAP_W-1:0]   cap_q, cap_d;
  logic [THR_W-1:0]   thr_q, thr_d;
  logic [FillW-1:0]   fill_q [2];
  logic [FillW-1:0]   fill_d [2];
  logic [KeyBits-1:0] qk_q [2][QueueDepth];
  logic [KeyBits-1:0] qk_d [2][QueueDepth];
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  logic               ram_we;
  logic [KeyBits-1:0] ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [CNT_W-1:0]   ram_rdata;

  logic               rm_en;
  logic [FillW-1:0]   rm_pos;
  logic               app_en;
  logic               out_free;
  logic               cfg_we;
  reg_idx_e           reg_idx;
  logic [CmpW-1:0]    cap_ext;
  logic [FillW-1:0]   eff_cap;
  logic [THR_W-1:0]   eff_thr;
  logic [CNT_W-1:0]   cnt_new;
  logic [FillW-1:0]   cur_fill;
  logic [KeyBits-1:0] cur_key;
  logic               scan_end;

  // count store
  lkc_ram #(
    .Width (CNT_W),
    .Depth (KeySpan)
  ) u_lkc_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (key_q),
    .rdata_o (ram_rdata)
  );

  // configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[REG_SEL_BIT]);

  always_comb begin
    cap_d  = cap_q;
    thr_d  = thr_q;
    prdata = '0;
    unique case (reg_idx)
      REG_CAPACITY: begin
        prdata = 32'(cap_q);
        if (cfg_we) begin
          cap_d = pwdata[CAP_W-1:0];
        end
      end
      REG_THRESHOLD: begin
        prdata = 32'(thr_q);
        if (cfg_we) begin
          thr_d = pwdata[THR_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  assign cap_ext = CmpW'(cap_q);

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = FillW'(1);
    end else if (cap_ext > CmpW'(QueueDepth)) begin
      eff_cap = FillW'(QueueDepth);
    end else begin
      eff_cap = FillW'(cap_ext);
    end
    if (thr_q < THR_MIN) begin
      eff_thr = THR_MIN;
    end else if (thr_q > THR_MAX) begin
      eff_thr = THR_MAX;
    end else begin
      eff_thr = thr_q;
    end
  end

  assign cnt_new  = (ram_rdata == CNT_MAX) ? CNT_MAX : ram_rdata + CNT_W'(1);
  assign cur_fill = fill_q[qsel_q];
  assign cur_key  = qk_q[qsel_q][scan_q[IdxW-1:0]];
  assign scan_end = ((scan_q + FillW'(1)) == cur_fill);
  assign out_free = ~out_valid_q | out_o.ready;

  assign in_i.ready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    qsel_d    = qsel_q;
    outcome_d = outcome_q;
    key_d     = key_q;
    scan_d    = scan_q;
    pos_d     = pos_q;
    ev_d      = ev_q;
    ev_from_d = ev_from_q;
    victim_d  = victim_q;
    clr_d     = clr_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = key_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    rm_en     = 1'b0;
    rm_pos    = pos_q;
    app_en    = 1'b0;
    out_valid_d = out_valid_q & ~out_o.ready;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + KeyBits'(1);
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          key_d  = in_i.access_key;
          scan_d = '0;
          if (in_i.action) begin
            qsel_d  = (fill_q[Q_HIST] == '0) ? Q_CACHE : Q_HIST;
            state_d = S_DUMP;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_COUNT;
      end
      S_COUNT: begin
        ram_we    = 1'b1;
        ram_wdata = cnt_new;
        ev_d      = 1'b0;
        ev_from_d = Q_HIST;
        scan_d    = '0;
        if (cnt_new == CNT_W'(1)) begin
          outcome_d = OUT_NEW;
          op_d      = OP_INSERT;
          qsel_d    = Q_HIST;
          state_d   = S_EVICT;
        end else if (cnt_new < eff_thr) begin
          outcome_d = OUT_HIST_REFRESH;
          op_d      = OP_REFRESH;
          qsel_d    = Q_HIST;
          state_d   = S_SCAN;
        end else if (cnt_new == eff_thr) begin
          outcome_d = OUT_PROMOTED;
          op_d      = OP_PROMO_HIST;
          qsel_d    = Q_HIST;
          state_d   = S_SCAN;
        end else begin
          outcome_d = OUT_CACHE_REFRESH;
          op_d      = OP_REFRESH;
          qsel_d    = Q_CACHE;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        // one slot per cycle through the shared comparator
        if (scan_q >= cur_fill) begin
          case (op_q)
            OP_PROMO_HIST: begin
              op_d   = OP_PROMO_CACHE;
              qsel_d = Q_CACHE;
              scan_d = '0;
            end
            OP_PROMO_CACHE: state_d = S_EVICT;
            default:        state_d = S_RESULT;
          endcase
        end else if (cur_key == key_q) begin
          pos_d   = scan_q;
          state_d = S_REMOVE;
        end else begin
          scan_d = scan_q + FillW'(1);
        end
      end
      S_REMOVE: begin
        rm_en = 1'b1;
        if (op_q == OP_PROMO_HIST) begin
          op_d    = OP_PROMO_CACHE;
          qsel_d  = Q_CACHE;
          scan_d  = '0;
          state_d = S_SCAN;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_EVICT: begin
        if (cur_fill >= eff_cap && cur_fill != '0) begin
          rm_en     = 1'b1;
          rm_pos    = '0;
          ev_d      = 1'b1;
          ev_from_d = qsel_q;
          victim_d  = qk_q[qsel_q][0];
          ram_we    = 1'b1;
          ram_waddr = qk_q[qsel_q][0];
        end
        state_d = S_APPEND;
      end
      S_APPEND: begin
        app_en  = (cur_fill < FillW'(QueueDepth));
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.outcome       = outcome_q;
          res_d.evicted_valid = ev_q;
          res_d.evicted_key   = ev_q ? victim_q : '0;
          res_d.evicted_from  = ev_q ? ev_from_q : Q_HIST;
          res_d.dump_valid    = 1'b0;
          res_d.dump_key      = '0;
          res_d.dump_queue    = Q_HIST;
          res_d.last          = 1'b1;
          state_d             = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          res_d.outcome       = OUT_DUMP;
          res_d.evicted_valid = 1'b0;
          res_d.evicted_key   = '0;
          res_d.evicted_from  = Q_HIST;
          if (cur_fill == '0) begin
            // both queues empty
            res_d.dump_valid = 1'b0;
            res_d.dump_key   = '0;
            res_d.dump_queue = Q_HIST;
            res_d.last       = 1'b1;
            state_d          = S_IDLE;
          end else begin
            res_d.dump_valid = 1'b1;
            res_d.dump_key   = cur_key;
            res_d.dump_queue = qsel_q;
            res_d.last       = scan_end &&
                               (qsel_q == Q_CACHE || fill_q[Q_CACHE] == '0);
            if (res_d.last) begin
              state_d = S_IDLE;
            end else if (scan_end) begin
              qsel_d = Q_CACHE;
              scan_d = '0;
            end else begin
              scan_d = scan_q + FillW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // queue update: shift out one slot, or append at the tail
  always_comb begin
    qk_d   = qk_q;
    fill_d = fill_q;
    if (rm_en) begin
      for (int i = 0; i < int'(QueueDepth) - 1; i++) begin
        if (FillW'(i) >= rm_pos && FillW'(i + 1) < cur_fill) begin
          qk_d[qsel_q][i] = qk_q[qsel_q][i + 1];
        end
      end
      fill_d[qsel_q] = cur_fill - FillW'(1);
    end else if (app_en) begin
      qk_d[qsel_q][cur_fill[IdxW-1:0]] = key_q;
      fill_d[qsel_q] = cur_fill + FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      op_q        <= OP_INSERT;
      qsel_q      <= Q_HIST;
      outcome_q   <= OUT_NEW;
      scan_q      <= '0;
      pos_q       <= '0;
      ev_q        <= 1'b0;
      ev_from_q   <= Q_HIST;
      clr_q       <= '0;
      cap_q       <= CAP_RESET;
      thr_q       <= THR_RESET;
      fill_q[0]   <= '0;
      fill_q[1]   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      qsel_q      <= qsel_d;
      outcome_q   <= outcome_d;
      scan_q      <= scan_d;
      pos_q       <= pos_d;
      ev_q        <= ev_d;
      ev_from_q   <= ev_from_d;
      clr_q       <= clr_d;
      cap_q       <= cap_d;
      thr_q       <= thr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    victim_q <= victim_d;
    qk_q     <= qk_d;
    res_q    <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.outcome       = res_q.outcome;
  assign out_o.evicted_valid = res_q.evicted_valid;
  assign out_o.evicted_key   = res_q.evicted_key;
  assign out_o.evicted_from  = res_q.evicted_from;
  assign out_o.dump_valid    = res_q.dump_valid;
  assign out_o.dump_key      = res_q.dump_key;
  assign out_o.dump_queue    = res_q.dump_queue;
  assign out_o.last          = res_q.last;

endmodule

`default_nettype wire

// File: sv/lkc_ram.sv
// ----------------------------------------------------------------------------
// lkc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lkc_ram import lkc_pkg::*; #(
  parameter int unsigned Width = CNT_W,
  parameter int unsigned Depth = 2 ** KEY_BITS_DEF,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/lkc_checker.sv
// ----------------------------------------------------------------------------
// lkc_checker
// port-level checks of the lru-k cache policy core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lru_k_cache_policy_core_defines.svh"

module lkc_checker import lkc_pkg::*; #(
  parameter int unsigned KeyBits = KEY_BITS_DEF
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic [2:0]         outcome_i,
  input wire logic               evicted_valid_i,
  input wire logic               dump_valid_i,
  input wire logic [KeyBits-1:0] dump_key_i,
  input wire logic               last_i
);

  // a stalled result holds
  `LKC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(outcome_i) && $stable(dump_key_i) && $stable(last_i), "result changed while stalled")

  // one item at a time
  `LKC_ASSERT(a_busy_after_accept, in_valid_i && in_ready_i |=> !in_ready_i, "input taken while busy")

  // an access gives a single result and never a dump entry
  `LKC_ASSERT(a_access_single, out_valid_i && outcome_i != OUT_DUMP |-> last_i && !dump_valid_i, "access result malformed")

  // only an insert into a full queue evicts
  `LKC_ASSERT(a_evict_outcome, out_valid_i && evicted_valid_i |-> (outcome_i == OUT_NEW || outcome_i == OUT_PROMOTED), "eviction on a refresh")

  // nothing moves while in reset
  `LKC_ASSERT_CLK(a_reset_quiet, !rst_ni |-> !out_valid_i && !in_ready_i, "activity during reset")

endmodule

bind lru_k_cache_policy_core lkc_checker #(
  .KeyBits (KeyBits)
) u_lkc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .outcome_i       (out_o.outcome),
  .evicted_valid_i (out_o.evicted_valid),
  .dump_valid_i    (out_o.dump_valid),
  .dump_key_i      (out_o.dump_key),
  .last_i          (out_o.last)
);

`default_nettype wire

// File: sim/lkc_checker.sv
// ----------------------------------------------------------------------------
// lkc_tb_checker
// watches the channels and the register port of the lru-k policy core, keeps
// its own copy of the counts and both queues, and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkc_tb_checker import lkc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lkc_in_if                  in_mon,
  lkc_out_if                 out_mon,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int unsigned        fail_count_o,
  output int unsigned        results_due_o
);

  localparam int unsigned KW = KEY_BITS_DEF;

  typedef logic [KW-1:0] key_t;

  typedef struct packed {
    outcome_e outcome;
    logic     evicted_valid;
    key_t     evicted_key;
    queue_e   evicted_from;
    logic     dump_valid;
    key_t     dump_key;
    queue_e   dump_queue;
    logic     last;
  } policy_result_t;

  logic [CNT_W-1:0] access_count [1 << KW];
  key_t             lru_q [2][$];
  logic [CAP_W-1:0] capacity_reg;
  logic [THR_W-1:0] threshold_reg;
  policy_result_t   results_due [$];
  policy_result_t   got;
  policy_result_t   want;

  task automatic report_mismatch(input string msg);
    fail_count_o++;
    $display("%0t lkc_tb_checker: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] g, input logic [31:0] w);
    if (g !== w) report_mismatch($sformatf("%s got %0h expected %0h", name, g, w));
  endtask

  function automatic int find_key(input queue_e which, input key_t key);
    for (int i = 0; i < lru_q[which].size(); i++) begin
      if (lru_q[which][i] == key) return i;
    end
    return -1;
  endfunction

  // absent keys are left alone
  function automatic void move_to_newest(input queue_e which, input key_t key);
    int pos;
    pos = find_key(which, key);
    if (pos >= 0) begin
      lru_q[which].delete(pos);
      lru_q[which].push_back(key);
    end
  endfunction

  // a full (or over-full) queue loses only its single oldest key
  function automatic void append_evict(input queue_e which, input int unsigned cap,
                                       input key_t key, inout policy_result_t r);
    key_t victim;
    if (lru_q[which].size() >= cap && lru_q[which].size() > 0) begin
      victim = lru_q[which].pop_front();
      access_count[victim] = '0;
      r.evicted_valid = 1'b1;
      r.evicted_key   = victim;
      r.evicted_from  = which;
    end
    if (lru_q[which].size() < QUEUE_DEPTH_DEF) lru_q[which].push_back(key);
  endfunction

  function automatic void apply_access(input key_t key);
    int unsigned      cap_eff;
    int unsigned      k_eff;
    logic [CNT_W-1:0] cnt;
    int               pos;
    policy_result_t   r;
    cap_eff = (capacity_reg == 0) ? 1 :
              (capacity_reg > QUEUE_DEPTH_DEF) ? QUEUE_DEPTH_DEF : capacity_reg;
    k_eff = (threshold_reg < THR_MIN) ? THR_MIN :
            (threshold_reg > THR_MAX) ? THR_MAX : threshold_reg;
    cnt = access_count[key];
    if (cnt != CNT_MAX) cnt++;
    access_count[key] = cnt;
    r = '0;
    r.last = 1'b1;
    if (cnt == 1) begin
      r.outcome = OUT_NEW;
      append_evict(Q_HIST, cap_eff, key, r);
    end else if (cnt < k_eff) begin
      r.outcome = OUT_HIST_REFRESH;
      move_to_newest(Q_HIST, key);
    end else if (cnt == k_eff) begin
      r.outcome = OUT_PROMOTED;
      pos = find_key(Q_HIST, key);
      if (pos >= 0) lru_q[Q_HIST].delete(pos);
      // promotion of a key that is already cached only refreshes it
      if (find_key(Q_CACHE, key) >= 0) move_to_newest(Q_CACHE, key);
      else append_evict(Q_CACHE, cap_eff, key, r);
    end else begin
      r.outcome = OUT_CACHE_REFRESH;
      move_to_newest(Q_CACHE, key);
    end
    results_due.push_back(r);
  endfunction

  function automatic void list_queues();
    policy_result_t r;
    int             n;
    n = 0;
    for (int i = 0; i < lru_q[Q_HIST].size(); i++) begin
      r = '0;
      r.outcome    = OUT_DUMP;
      r.dump_valid = 1'b1;
      r.dump_key   = lru_q[Q_HIST][i];
      r.dump_queue = Q_HIST;
      results_due.push_back(r);
      n++;
    end
    for (int i = 0; i < lru_q[Q_CACHE].size(); i++) begin
      r = '0;
      r.outcome    = OUT_DUMP;
      r.dump_valid = 1'b1;
      r.dump_key   = lru_q[Q_CACHE][i];
      r.dump_queue = Q_CACHE;
      results_due.push_back(r);
      n++;
    end
    // both queues empty: a single marker entry
    if (n == 0) begin
      r = '0;
      r.outcome = OUT_DUMP;
      results_due.push_back(r);
    end
    results_due[results_due.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < (1 << KW); i++) access_count[i] = '0;
      lru_q[Q_HIST].delete();
      lru_q[Q_CACHE].delete();
      results_due.delete();
      capacity_reg  = CAP_RESET;
      threshold_reg = THR_RESET;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.outcome       = outcome_e'(out_mon.outcome);
        got.evicted_valid = out_mon.evicted_valid;
        got.evicted_key   = out_mon.evicted_key;
        got.evicted_from  = queue_e'(out_mon.evicted_from);
        got.dump_valid    = out_mon.dump_valid;
        got.dump_key      = out_mon.dump_key;
        got.dump_queue    = queue_e'(out_mon.dump_queue);
        got.last          = out_mon.last;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with none expected, outcome %0h",
                                    out_mon.outcome));
        end else begin
          want = results_due.pop_front();
          check_field("outcome", out_mon.outcome, want.outcome);
          check_field("evicted_valid", got.evicted_valid, want.evicted_valid);
          check_field("evicted_key", got.evicted_key, want.evicted_key);
          check_field("evicted_from", out_mon.evicted_from, want.evicted_from);
          check_field("dump_valid", got.dump_valid, want.dump_valid);
          check_field("dump_key", got.dump_key, want.dump_key);
          check_field("dump_queue", out_mon.dump_queue, want.dump_queue);
          check_field("last", got.last, want.last);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        // action high requests a dump
        if (in_mon.action) list_queues();
        else apply_access(in_mon.access_key);
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[PADDR_W-1:REG_SEL_BIT]))
          REG_CAPACITY:  capacity_reg  = pwdata_i[CAP_W-1:0];
          REG_THRESHOLD: threshold_reg = pwdata_i[THR_W-1:0];
          default: ;
        endcase
      end
    end
    results_due_o = results_due.size();
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives accesses and dumps into the lru-k policy core through several
// register settings and idle patterns; the checker does the comparing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lkc_pkg::*;

  localparam int unsigned KW           = KEY_BITS_DEF;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned SETTLE       = 48;
  localparam int unsigned LONG_HOLD    = 300;
  localparam logic        ACT_ACCESS   = 1'b0;
  localparam logic        ACT_DUMP     = 1'b1;

  typedef logic [KW-1:0] key_t;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int unsigned        fail_count;
  int unsigned        results_due;
  int unsigned        send_idle_pct;
  int unsigned        recv_stall_pct;
  int unsigned        hold_trigger;
  int unsigned        hold_seen;
  int unsigned        hold_left;
  int unsigned        quiet_cycles;
  key_t               key_pool [$];

  lkc_in_if  in_if ();
  lkc_out_if out_if ();

  lru_k_cache_policy_core u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lkc_tb_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_if),
    .out_mon       (out_if),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pready_i      (pready),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side: random stalls, plus a long hold-off when triggered
  initial begin
    out_if.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ends the run when no transaction moves for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable && pready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic offer_item(input logic act, input key_t key);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.action     = act;
    in_if.access_key = key;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(int'(idx) << REG_SEL_BIT);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // mostly repeated keys from a small pool so counts climb and queues fill,
  // with some dumps and some one-off keys
  task automatic run_phase(input int unsigned cap, input int unsigned thr,
                           input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_items, input int unsigned pool_size,
                           input bit long_hold, input bit mid_drain);
    int unsigned pick;
    drain_results();
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_THRESHOLD, thr);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    key_pool.delete();
    repeat (pool_size) key_pool.push_back(key_t'($urandom_range((1 << KW) - 1)));
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        if (long_hold) hold_trigger++;
        if (mid_drain) drain_results();
      end
      pick = $urandom_range(99);
      if (pick < 9)
        offer_item(ACT_DUMP, key_t'($urandom_range((1 << KW) - 1)));
      else if (pick < 14)
        offer_item(ACT_ACCESS, key_t'($urandom_range((1 << KW) - 1)));
      else
        offer_item(ACT_ACCESS, key_pool[$urandom_range(pool_size - 1)]);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = ACT_ACCESS;
    in_if.access_key = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_trigger     = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: dump of empty queues, new keys, promotion, cache refresh
    offer_item(ACT_DUMP, '1);
    offer_item(ACT_ACCESS, '0);
    offer_item(ACT_ACCESS, '1);
    offer_item(ACT_ACCESS, '0);
    offer_item(ACT_ACCESS, '0);
    offer_item(ACT_DUMP, '0);

    // single-entry queues: history and cache evictions, a cleared count
    drain_results();
    write_reg(REG_CAPACITY, 1);
    write_reg(REG_THRESHOLD, 3);
    offer_item(ACT_ACCESS, 10'h155);
    offer_item(ACT_ACCESS, 10'h2aa);
    offer_item(ACT_ACCESS, 10'h2aa);
    offer_item(ACT_ACCESS, 10'h2aa);
    offer_item(ACT_ACCESS, '0);
    offer_item(ACT_ACCESS, '0);
    offer_item(ACT_ACCESS, '0);
    offer_item(ACT_DUMP, 10'h2aa);

    run_phase(16,  2,  0,  0, 60, 12, 1'b1, 1'b0);
    run_phase( 4,  5, 57,  0, 60, 10, 1'b0, 1'b1);
    run_phase( 1, 14,  0, 57, 40,  4, 1'b0, 1'b0);
    run_phase( 0,  1, 10, 10, 45,  8, 1'b0, 1'b0);
    run_phase(31, 15,  0,  0, 55,  3, 1'b0, 1'b0);
    run_phase(17,  0,  0, 57, 50, 20, 1'b0, 1'b0);
    run_phase( 3,  4, 57,  0, 45,  6, 1'b0, 1'b0);

    drain_results();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
